FILE: rtl/dsbf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsbf_pkg
// Shared types and constants of the lighting slice buffer: word layouts,
// command codes, configuration register map and reset values.
// ----------------------------------------------------------------------------
package dsbf_pkg;

  // Default number of stored channel levels
  localparam int unsigned Channels = 512;

  // Configuration port geometry
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Command queue between front and back (power of two)
  localparam int unsigned QDepth = 2;

  // Width used to compare channel numbers against counts up to 1024
  localparam int unsigned CmpW = 11;

  // Saturation limits of the millisecond counters
  localparam logic [15:0] SilenceMax  = 16'hFFFF;
  localparam logic [9:0]  SinceFadeMax = 10'h3FF;

  // Configuration reset values
  localparam logic [14:0] RstSourceUniverse = 15'd1;
  localparam logic [9:0]  RstSliceFirst     = 10'd1;
  localparam logic [9:0]  RstSliceLast      = 10'd512;
  localparam logic        RstSlicePass      = 1'b0;
  localparam logic [15:0] RstSilenceLimit   = 16'd5000;
  localparam logic [9:0]  RstFadePeriod     = 10'd50;
  localparam logic [7:0]  RstFadeAmount     = 8'd5;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_SOURCE_UNIVERSE  = 3'd0,
    REG_SLICE_FIRST      = 3'd1,
    REG_SLICE_LAST       = 3'd2,
    REG_SLICE_PASS       = 3'd3,
    REG_SILENCE_LIMIT_MS = 3'd4,
    REG_FADE_PERIOD_MS   = 3'd5,
    REG_FADE_AMOUNT      = 3'd6
  } cfg_reg_e;

  // Input operation codes
  typedef enum logic [1:0] {
    OP_LEVEL = 2'd0,
    OP_TICK  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // Classified commands handed to the back end
  typedef enum logic [1:0] {
    CMD_STORE = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [14:0] universe;
    logic        packet_first;
    logic        packet_last;
    logic [7:0]  level;
    logic [9:0]  channel;
  } in_t;

  typedef struct packed {
    logic [7:0]  read_level;
    logic        signal_live;
    logic        fading_now;
    logic [31:0] packets_taken;
  } out_t;

  typedef struct packed {
    logic [14:0] source_universe;
    logic [9:0]  slice_first;
    logic [9:0]  slice_last;
    logic        slice_pass;
    logic [15:0] silence_limit_ms;
    logic [9:0]  fade_period_ms;
    logic [7:0]  fade_amount;
  } cfg_t;

  typedef struct packed {
    cmd_e       kind;
    logic       first;
    logic       last;
    logic [7:0] level;
    logic [9:0] channel;
  } cmd_t;

endpackage
`default_nettype wire

FILE: rtl/dsbf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsbf_front
// Accepts input words, classifies them into commands and holds them in a
// short queue until the back end takes them.
// ----------------------------------------------------------------------------
module dsbf_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  dsbf_pkg::in_t       in_data_i,
  input  wire [14:0]          source_universe_i,
  output logic                cmd_valid_o,
  output dsbf_pkg::cmd_t      cmd_o,
  input  wire                 cmd_pop_i
);

  localparam int unsigned PtrW = (dsbf_pkg::QDepth > 1) ? $clog2(dsbf_pkg::QDepth) : 1;
  localparam int unsigned CntW = $clog2(dsbf_pkg::QDepth + 1);

  dsbf_pkg::cmd_t entries_q [dsbf_pkg::QDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  dsbf_pkg::cmd_t  cmd_new;
  logic            push;

  // Classify the incoming word
  always_comb begin
    cmd_new.first   = in_data_i.packet_first;
    cmd_new.last    = in_data_i.packet_last;
    cmd_new.level   = in_data_i.level;
    cmd_new.channel = in_data_i.channel;
    case (in_data_i.operation)
      dsbf_pkg::OP_LEVEL: begin
        cmd_new.kind = (in_data_i.universe == source_universe_i) ? dsbf_pkg::CMD_STORE
                                                                 : dsbf_pkg::CMD_NOP;
      end
      dsbf_pkg::OP_TICK: cmd_new.kind = dsbf_pkg::CMD_TICK;
      dsbf_pkg::OP_READ: cmd_new.kind = dsbf_pkg::CMD_READ;
      default:           cmd_new.kind = dsbf_pkg::CMD_NOP;
    endcase
  end

  assign in_ready_o  = (count_q != CntW'(dsbf_pkg::QDepth));
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = entries_q[rd_ptr_q];

  // Advance queue pointers and occupancy
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = cmd_pop_i ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push && !cmd_pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (!push && cmd_pop_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Hold queued commands
  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/dsbf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsbf_back
// Executes queued commands: stores packet levels, counts silence, walks the
// level store for fade steps, answers reads and registers the result word.
// ----------------------------------------------------------------------------
module dsbf_back #(
  parameter int unsigned CHANNELS = dsbf_pkg::Channels
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  dsbf_pkg::cfg_t      cfg_i,
  input  wire                 cmd_valid_i,
  input  dsbf_pkg::cmd_t      cmd_i,
  output logic                cmd_pop_o,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output dsbf_pkg::out_t      out_data_o
);

  localparam int unsigned AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned LW = $clog2(CHANNELS + 1);
  localparam int unsigned CW = dsbf_pkg::CmpW;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_FADE = 3'b010,
    ST_RESP = 3'b100
  } state_e;

  state_e       st_q, st_d;
  logic [LW-1:0] fill_q, fill_d;
  logic [15:0]  silence_q, silence_d;
  logic [9:0]   since_q, since_d;
  logic         signal_q, signal_d;
  logic         fade_q, fade_d;
  logic [31:0]  count_q, count_d;
  logic [LW-1:0] rd_idx_q, rd_idx_d;
  logic         wr_pend_q, wr_pend_d;
  logic [AW-1:0] wr_addr_q, wr_addr_d;
  logic         nonzero_q, nonzero_d;
  logic         read_ok_q, read_ok_d;
  logic         out_valid_q;
  dsbf_pkg::out_t out_q;

  // Level store
  logic [7:0]    mem_q [CHANNELS];
  logic [7:0]    rdata_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata;

  logic [LW-1:0] wp;
  logic [15:0]   silence_n;
  logic [9:0]    since_n;
  logic [CW-1:0] ch_x;
  logic          rd_ok;
  logic          walk_more;
  logic [7:0]    faded;
  logic          out_load;

  assign wp        = cmd_i.first ? '0 : fill_q;
  assign silence_n = (silence_q < dsbf_pkg::SilenceMax) ? silence_q + 16'd1 : silence_q;
  assign since_n   = (since_q < dsbf_pkg::SinceFadeMax) ? since_q + 10'd1 : since_q;
  assign ch_x      = CW'(cmd_i.channel);
  assign rd_ok     = (ch_x != '0) && (ch_x <= CW'(CHANNELS)) && (ch_x <= CW'(fill_q)) &&
                     (cfg_i.slice_pass ||
                      ((ch_x >= CW'(cfg_i.slice_first)) && (ch_x <= CW'(cfg_i.slice_last))));
  assign walk_more = (rd_idx_q < fill_q);
  assign faded     = (rdata_q > cfg_i.fade_amount) ? rdata_q - cfg_i.fade_amount : 8'd0;
  assign out_load  = (st_q == ST_RESP) && (!out_valid_q || out_ready_i);
  assign cmd_pop_o = (st_q == ST_IDLE) && cmd_valid_i;

  // Execute commands and sequence the fade walk
  always_comb begin
    st_d      = st_q;
    fill_d    = fill_q;
    silence_d = silence_q;
    since_d   = since_q;
    signal_d  = signal_q;
    fade_d    = fade_q;
    count_d   = count_q;
    rd_idx_d  = rd_idx_q;
    wr_pend_d = wr_pend_q;
    wr_addr_d = wr_addr_q;
    nonzero_d = nonzero_q;
    read_ok_d = read_ok_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    case (st_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          st_d      = ST_RESP;
          read_ok_d = 1'b0;
          case (cmd_i.kind)
            dsbf_pkg::CMD_STORE: begin
              // Append the level; drop it once the store is full
              if (wp < LW'(CHANNELS)) begin
                mem_we    = 1'b1;
                mem_waddr = wp[AW-1:0];
                mem_wdata = cmd_i.level;
                fill_d    = wp + LW'(1);
              end else begin
                fill_d = wp;
              end
              if (cmd_i.last) begin
                count_d   = count_q + 32'd1;
                silence_d = '0;
                signal_d  = 1'b1;
                fade_d    = 1'b0;
              end
            end
            dsbf_pkg::CMD_TICK: begin
              silence_d = silence_n;
              since_d   = since_n;
              if (signal_q && (silence_n > cfg_i.silence_limit_ms)) begin
                fade_d = 1'b1;
                if (since_n >= cfg_i.fade_period_ms) begin
                  since_d   = '0;
                  rd_idx_d  = '0;
                  wr_pend_d = 1'b0;
                  nonzero_d = 1'b0;
                  st_d      = ST_FADE;
                end
              end
            end
            dsbf_pkg::CMD_READ: begin
              read_ok_d = rd_ok;
              mem_re    = rd_ok;
              mem_raddr = AW'(cmd_i.channel - 10'd1);
            end
            default: begin
            end
          endcase
        end
      end
      ST_FADE: begin
        // Read one entry, write back the entry read in the cycle before unless it is zero
        if (walk_more) begin
          mem_re    = 1'b1;
          mem_raddr = rd_idx_q[AW-1:0];
          rd_idx_d  = rd_idx_q + LW'(1);
          wr_addr_d = rd_idx_q[AW-1:0];
        end
        wr_pend_d = walk_more;
        if (wr_pend_q && (rdata_q != 8'd0)) begin
          mem_we    = 1'b1;
          mem_waddr = wr_addr_q;
          mem_wdata = faded;
          nonzero_d = 1'b1;
        end
        // Drop the signal when the step found everything dark
        if (!walk_more && !wr_pend_q) begin
          if (!nonzero_q) begin
            fade_d   = 1'b0;
            signal_d = 1'b0;
          end
          st_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_load) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      fill_q      <= '0;
      silence_q   <= '0;
      since_q     <= dsbf_pkg::SinceFadeMax;
      signal_q    <= 1'b0;
      fade_q      <= 1'b0;
      count_q     <= '0;
      rd_idx_q    <= '0;
      wr_pend_q   <= 1'b0;
      nonzero_q   <= 1'b0;
      read_ok_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      fill_q    <= fill_d;
      silence_q <= silence_d;
      since_q   <= since_d;
      signal_q  <= signal_d;
      fade_q    <= fade_d;
      count_q   <= count_d;
      rd_idx_q  <= rd_idx_d;
      wr_pend_q <= wr_pend_d;
      nonzero_q <= nonzero_d;
      read_ok_q <= read_ok_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Register the result word and the fade write-back address
  always_ff @(posedge clk_i) begin
    wr_addr_q <= wr_addr_d;
    if (out_load) begin
      out_q.read_level    <= read_ok_q ? rdata_q : 8'd0;
      out_q.signal_live   <= signal_q;
      out_q.fading_now    <= fade_q;
      out_q.packets_taken <= count_q;
    end
  end

  // Level store ports
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_fade_needs_signal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fade_q |-> signal_q)
    else $error("fade active without signal");

  a_fill_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= LW'(CHANNELS))
    else $error("fill count beyond store depth");

  a_walk_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_FADE) |-> (rd_idx_q <= fill_q))
    else $error("fade walk past loaded length");

  a_resp_data_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((st_q == ST_RESP) && $past(st_q == ST_RESP)) |-> $stable(rdata_q))
    else $error("read data changed while result pending");

endmodule
`default_nettype wire

FILE: rtl/dmx_slice_buffer_with_fade.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmx_slice_buffer_with_fade
// One-universe lighting level buffer with slice read-out and fade to black
// after a silence timeout. Holds the configuration registers.
// ----------------------------------------------------------------------------
//  Channel   Handshake                  Word
//  input     in_valid_i / in_ready_o    in_data_i  (dsbf_pkg::in_t)
//  output    out_valid_o / out_ready_i  out_data_o (dsbf_pkg::out_t)
//  config    cfg_we_i                   cfg_idx_i, cfg_data_i
//
//  A word executes in the back end idle state; the response state loads
//  the result register, waiting on output stalls. A tick starting a fade
//  step walks the loaded length, reading one level store entry per cycle
//  through its single read port, writing it back in the cycle after.
//  A two-word queue lets input be taken while the back end walks or stalls.
//  Reset clears all control state; the level store is not cleared.
// ----------------------------------------------------------------------------
module dmx_slice_buffer_with_fade #(
  parameter int unsigned CHANNELS = dsbf_pkg::Channels
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            in_valid_i,
  output logic                           in_ready_o,
  input  dsbf_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  wire                            out_ready_i,
  output dsbf_pkg::out_t                 out_data_o,
  input  wire                            cfg_we_i,
  input  wire [dsbf_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire [dsbf_pkg::CfgDataW-1:0]   cfg_data_i
);

  dsbf_pkg::cfg_t cfg_q;
  logic           cmd_valid;
  dsbf_pkg::cmd_t cmd;
  logic           cmd_pop;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.source_universe  <= dsbf_pkg::RstSourceUniverse;
      cfg_q.slice_first      <= dsbf_pkg::RstSliceFirst;
      cfg_q.slice_last       <= dsbf_pkg::RstSliceLast;
      cfg_q.slice_pass       <= dsbf_pkg::RstSlicePass;
      cfg_q.silence_limit_ms <= dsbf_pkg::RstSilenceLimit;
      cfg_q.fade_period_ms   <= dsbf_pkg::RstFadePeriod;
      cfg_q.fade_amount      <= dsbf_pkg::RstFadeAmount;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dsbf_pkg::REG_SOURCE_UNIVERSE:  cfg_q.source_universe  <= cfg_data_i[14:0];
        dsbf_pkg::REG_SLICE_FIRST:      cfg_q.slice_first      <= cfg_data_i[9:0];
        dsbf_pkg::REG_SLICE_LAST:       cfg_q.slice_last       <= cfg_data_i[9:0];
        dsbf_pkg::REG_SLICE_PASS:       cfg_q.slice_pass       <= cfg_data_i[0];
        dsbf_pkg::REG_SILENCE_LIMIT_MS: cfg_q.silence_limit_ms <= cfg_data_i[15:0];
        dsbf_pkg::REG_FADE_PERIOD_MS:   cfg_q.fade_period_ms   <= cfg_data_i[9:0];
        dsbf_pkg::REG_FADE_AMOUNT:      cfg_q.fade_amount      <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  // Accept and classify
  dsbf_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .in_data_i         (in_data_i),
    .source_universe_i (cfg_q.source_universe),
    .cmd_valid_o       (cmd_valid),
    .cmd_o             (cmd),
    .cmd_pop_i         (cmd_pop)
  );

  // Execute and answer
  dsbf_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire
